// ===== hdl/cdoe_pkg.sv =====
// Shared constants, types and state encoding for the clock drift/offset estimator.
`default_nettype none

package cdoe_pkg;

    localparam int FRAC_BITS = 32;
    localparam int WORD_W    = 64;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 8;

    localparam int DIFF_W    = WORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int DVD_W     = 2 * WORD_W;
    localparam int T_W       = PROD_W + 2;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);
    localparam int MUL_CNT_W = $clog2(DIFF_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_OFFSET = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SCALE  = CFG_IDX_W'(1);

    localparam logic [WORD_W-1:0] SCALE_ONE = WORD_W'(1) << FRAC_BITS;
    localparam logic [WORD_W-1:0] MIN_MAG   = WORD_W'(1) << (WORD_W - 1);
    localparam logic [WORD_W-1:0] MAX_POS   = ~MIN_MAG;
    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SDIV,
        ST_SCALE,
        ST_MUL,
        ST_OFFS,
        ST_ACC,
        ST_UPD,
        ST_EDIV_O,
        ST_EDIV_S,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic long_div;
    } div_req_t;

endpackage

`default_nettype wire

// ===== hdl/cdoe_div.sv =====
// Serial restoring divider, one quotient bit per cycle, 128 or 64 steps.
`default_nettype none

module cdoe_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cdoe_pkg::div_req_t            req,
    input  logic [cdoe_pkg::DVD_W-1:0]    dividend,
    input  logic [cdoe_pkg::WORD_W-1:0]   divisor,
    output logic                          done,
    output logic [cdoe_pkg::DVD_W-1:0]    quotient
);
    import cdoe_pkg::*;

    logic [DVD_W-1:0]     dq_reg, dq_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [WORD_W:0]      rem_shift;
    logic                 ge;

    // dividend shifts out at the top while quotient bits enter at the bottom
    always_comb
    begin
        rem_shift = {rem_reg, dq_reg[DVD_W-1]};
        ge        = rem_shift >= {1'b0, dvs_reg};
        rem_next  = ge ? WORD_W'(rem_shift - {1'b0, dvs_reg}) : rem_shift[WORD_W-1:0];
        dq_next   = {dq_reg[DVD_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg  <= req.long_div ? DIV_CNT_W'(DVD_W) : DIV_CNT_W'(WORD_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

`default_nettype wire

// ===== hdl/cdoe_mul.sv =====
// Serial shift-add multiplier for unsigned magnitudes, one multiplier bit per cycle.
`default_nettype none

module cdoe_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cdoe_pkg::WORD_W-1:0]   mcand,
    input  logic [cdoe_pkg::DIFF_W-1:0]   mplier,
    output logic                          done,
    output logic [cdoe_pkg::PROD_W-1:0]   product
);
    import cdoe_pkg::*;

    logic [DIFF_W-1:0]    hi_reg;
    logic [DIFF_W-1:0]    lo_reg;
    logic [WORD_W-1:0]    mcand_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIFF_W:0]      psum;

    always_comb
    begin
        psum = {1'b0, hi_reg}
             + (lo_reg[0] ? (DIFF_W + 1)'(mcand_reg) : (DIFF_W + 1)'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= MUL_CNT_W'(DIFF_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - MUL_CNT_W'(1);
                if (cnt_reg == MUL_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg    <= '0;
            lo_reg    <= mplier;
            mcand_reg <= mcand;
        end
        else if (busy_reg)
        begin
            hi_reg <= psum[DIFF_W:1];
            lo_reg <= {psum[0], lo_reg[DIFF_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

`default_nettype wire

// ===== hdl/clock_drift_offset_estimator_core.sv =====
// Top level: sequencer, running sums and estimate registers around the shared divider and the multiplier.
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------------
//  in      | in_valid / in_ready   | time_ref, time_remote, update_estimate
//  out     | out_valid / out_ready | est_offset, est_scale, pairs_used, saturated
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An item with a usable interval runs the 128-step serial scale divide, then the 65-step serial
// offset multiply, and an estimate update adds two 64-step divides; an item with no interval
// skips the divide and the multiply. The next item is taken in the idle state once the result
// is loaded; in_ready is high only in the idle state.
// A result sits in the output register while the next item is accepted; one still not taken
// holds the next in ST_OUT. Asynchronous active-low reset; cfg writes are always taken.
`default_nettype none

module clock_drift_offset_estimator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [cdoe_pkg::WORD_W-1:0] time_ref,
    input  logic signed [cdoe_pkg::WORD_W-1:0] time_remote,
    input  logic                              update_estimate,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [cdoe_pkg::WORD_W-1:0] est_offset,
    output logic signed [cdoe_pkg::WORD_W-1:0] est_scale,
    output logic [cdoe_pkg::CNT_W-1:0]        pairs_used,
    output logic                              saturated,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cdoe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cdoe_pkg::WORD_W-1:0]       cfg_data
);
    import cdoe_pkg::*;

    function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? WORD_W'(-v) : v;
    endfunction

    state_t state_reg, state_next;

    logic                     have_prev_reg;
    logic [WORD_W-1:0]        prev_ref_reg, prev_remote_reg;
    logic [WORD_W-1:0]        a1_reg, b1_reg;
    logic                     upd_reg;
    logic                     dneg_reg;
    logic signed [DIFF_W-1:0] suma_reg, sumb_reg;
    logic [WORD_W-1:0]        scale_reg;
    logic [WORD_W-1:0]        offset_reg;
    logic                     sat_reg;
    logic [WORD_W-1:0]        sum_off_reg, sum_scl_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [WORD_W-1:0]        cur_off_reg, cur_scl_reg;
    logic                     out_valid_reg;
    logic [WORD_W-1:0]        out_off_reg, out_scl_reg;
    logic [CNT_W-1:0]         out_cnt_reg;
    logic                     out_sat_reg;

    // interval differences
    logic [DIFF_W-1:0]        da_fwd, da_bwd, db_fwd, db_bwd;
    logic                     dan, dbn;
    logic [WORD_W-1:0]        dam, dbm;

    // divider and multiplier hook-up
    div_req_t                 div_req;
    logic [DVD_W-1:0]         div_dividend;
    logic [WORD_W-1:0]        div_divisor;
    logic                     div_done;
    logic [DVD_W-1:0]         div_q;
    logic                     mul_start;
    logic                     mul_done;
    logic [PROD_W-1:0]        mul_p;

    // scale and offset arithmetic
    logic [WORD_W-1:0]        s_limit, s_mag, s_val;
    logic                     s_sat;
    logic signed [T_W-1:0]    t_val, t_shr;
    logic [T_W-WORD_W:0]      t_top;
    logic                     o_sat;
    logic [WORD_W-1:0]        o_val;
    logic [WORD_W:0]          add_off, add_scl;
    logic                     off_ovf, scl_ovf;
    logic [WORD_W-1:0]        q_signed;

    logic                     in_fire, out_load, interval;

    always_comb
    begin
        da_fwd   = {a1_reg[WORD_W-1], a1_reg} - {prev_ref_reg[WORD_W-1], prev_ref_reg};
        da_bwd   = {prev_ref_reg[WORD_W-1], prev_ref_reg} - {a1_reg[WORD_W-1], a1_reg};
        db_fwd   = {b1_reg[WORD_W-1], b1_reg} - {prev_remote_reg[WORD_W-1], prev_remote_reg};
        db_bwd   = {prev_remote_reg[WORD_W-1], prev_remote_reg}
                 - {b1_reg[WORD_W-1], b1_reg};
        dan      = da_fwd[DIFF_W-1];
        dbn      = db_fwd[DIFF_W-1];
        dam      = dan ? da_bwd[WORD_W-1:0] : da_fwd[WORD_W-1:0];
        dbm      = dbn ? db_bwd[WORD_W-1:0] : db_fwd[WORD_W-1:0];
        interval = have_prev_reg && (dam != '0);
    end

    // scale from the long divide; the limit is also the clipped magnitude
    always_comb
    begin
        s_limit = dneg_reg ? MIN_MAG : MAX_POS;
        s_sat   = (div_q[DVD_W-1:WORD_W] != '0) || (div_q[WORD_W-1:0] > s_limit);
        s_mag   = s_sat ? s_limit : div_q[WORD_W-1:0];
        s_val   = dneg_reg ? WORD_W'(-s_mag) : s_mag;
        q_signed = div_q[WORD_W-1:0];
    end

    // t = (b0+b1)*2^F - scale*(a0+a1), floor-shifted by F+1
    always_comb
    begin
        if (scale_reg[WORD_W-1] ^ suma_reg[DIFF_W-1])
            t_val = (T_W'(sumb_reg) <<< FRAC_BITS) + T_W'(mul_p);
        else
            t_val = (T_W'(sumb_reg) <<< FRAC_BITS) - T_W'(mul_p);
        t_shr = t_val >>> (FRAC_BITS + 1);
        t_top = t_shr[T_W-1:WORD_W-1];
        o_sat = !((&t_top) || !(|t_top));
        if (o_sat)
            o_val = t_shr[T_W-1] ? MIN_MAG : MAX_POS;
        else
            o_val = t_shr[WORD_W-1:0];
    end

    always_comb
    begin
        add_off = {sum_off_reg[WORD_W-1], sum_off_reg} + {offset_reg[WORD_W-1], offset_reg};
        add_scl = {sum_scl_reg[WORD_W-1], sum_scl_reg} + {scale_reg[WORD_W-1], scale_reg};
        off_ovf = add_off[WORD_W] != add_off[WORD_W-1];
        scl_ovf = add_scl[WORD_W] != add_scl[WORD_W-1];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_PREP;
            ST_PREP:   state_next = interval ? ST_SDIV : ST_UPD;
            ST_SDIV:   if (div_done) state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_MUL;
            ST_MUL:    if (mul_done) state_next = ST_OFFS;
            ST_OFFS:   state_next = ST_ACC;
            ST_ACC:    state_next = ST_UPD;
            ST_UPD:    state_next = (upd_reg && count_reg != '0) ? ST_EDIV_O : ST_OUT;
            ST_EDIV_O: if (div_done) state_next = ST_EDIV_S;
            ST_EDIV_S: if (div_done) state_next = ST_OUT;
            ST_OUT:    if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready         = 1'b0;
        div_req.start    = 1'b0;
        div_req.long_div = 1'b0;
        div_dividend     = {mag(sum_off_reg), WORD_W'(0)};
        div_divisor      = WORD_W'(count_reg);
        mul_start        = 1'b0;
        out_load         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_PREP:
            begin
                div_req.start    = interval;
                div_req.long_div = 1'b1;
                div_dividend     = DVD_W'(dbm) << FRAC_BITS;
                div_divisor      = dam;
            end
            ST_SCALE:
            begin
                mul_start = 1'b1;
            end
            ST_UPD:
            begin
                div_req.start = upd_reg && (count_reg != '0);
            end
            ST_EDIV_O:
            begin
                div_req.start = div_done;
                div_dividend  = {mag(sum_scl_reg), WORD_W'(0)};
            end
            ST_OUT:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            prev_ref_reg  <= '0;
            prev_remote_reg <= '0;
            sum_off_reg   <= '0;
            sum_scl_reg   <= '0;
            count_reg     <= '0;
            cur_off_reg   <= '0;
            cur_scl_reg   <= SCALE_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_PREP)
            begin
                have_prev_reg   <= 1'b1;
                prev_ref_reg    <= a1_reg;
                prev_remote_reg <= b1_reg;
            end

            if (state_reg == ST_ACC)
            begin
                if (off_ovf)
                    sum_off_reg <= add_off[WORD_W] ? MIN_MAG : MAX_POS;
                else
                    sum_off_reg <= add_off[WORD_W-1:0];
                if (scl_ovf)
                    sum_scl_reg <= add_scl[WORD_W] ? MIN_MAG : MAX_POS;
                else
                    sum_scl_reg <= add_scl[WORD_W-1:0];
                if (count_reg != CNT_MAX)
                    count_reg <= count_reg + CNT_W'(1);
            end

            // estimate: magnitude quotient, sign of the sum
            if (state_reg == ST_EDIV_O && div_done)
                cur_off_reg <= sum_off_reg[WORD_W-1] ? WORD_W'(-q_signed) : q_signed;
            if (state_reg == ST_EDIV_S && div_done)
                cur_scl_reg <= sum_scl_reg[WORD_W-1] ? WORD_W'(-q_signed) : q_signed;

            // a guess written before any interval also becomes the estimate
            if (cfg_valid && count_reg == '0)
            begin
                if (cfg_index == CFG_INITIAL_OFFSET)
                    cur_off_reg <= cfg_data;
                else if (cfg_index == CFG_INITIAL_SCALE)
                    cur_scl_reg <= cfg_data;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a1_reg  <= time_ref;
            b1_reg  <= time_remote;
            upd_reg <= update_estimate;
            sat_reg <= 1'b0;
        end
        if (state_reg == ST_PREP)
        begin
            dneg_reg <= dan ^ dbn;
            suma_reg <= {a1_reg[WORD_W-1], a1_reg} + {prev_ref_reg[WORD_W-1], prev_ref_reg};
            sumb_reg <= {b1_reg[WORD_W-1], b1_reg}
                      + {prev_remote_reg[WORD_W-1], prev_remote_reg};
        end
        if (state_reg == ST_SCALE)
        begin
            scale_reg <= s_val;
            if (s_sat)
                sat_reg <= 1'b1;
        end
        if (state_reg == ST_OFFS)
        begin
            offset_reg <= o_val;
            if (o_sat)
                sat_reg <= 1'b1;
        end
        if (state_reg == ST_ACC && (off_ovf || scl_ovf))
            sat_reg <= 1'b1;
        if (out_load)
        begin
            out_off_reg <= cur_off_reg;
            out_scl_reg <= cur_scl_reg;
            out_cnt_reg <= count_reg;
            out_sat_reg <= sat_reg;
        end
    end

    cdoe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // multiplicand is the clipped scale magnitude, taken straight from the divide
    cdoe_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (s_mag),
        .mplier  (suma_reg[DIFF_W-1] ? DIFF_W'(-suma_reg) : DIFF_W'(suma_reg)),
        .done    (mul_done),
        .product (mul_p)
    );

    assign out_valid  = out_valid_reg;
    assign est_offset = out_off_reg;
    assign est_scale  = out_scl_reg;
    assign pairs_used = out_cnt_reg;
    assign saturated  = out_sat_reg;

endmodule

`default_nettype wire

// ===== sim/clock_drift_offset_estimator_core_test.sv =====
// Self-checking testbench for the clock drift and offset estimator core.
module clock_drift_offset_estimator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cdoe_pkg::*;

    typedef logic signed [199:0] wide_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] offset;
        logic signed [WORD_W-1:0] scale;
        logic [CNT_W-1:0]         pairs;
        logic                     clipped;
    } estimate_t;

    localparam wide_t WIDE_TOP = (wide_t'(1) <<< (WORD_W - 1)) - 1;
    localparam wide_t WIDE_BOT = -(wide_t'(1) <<< (WORD_W - 1));
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [WORD_W-1:0] time_ref = '0;
    logic signed [WORD_W-1:0] time_remote = '0;
    logic update_estimate = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [WORD_W-1:0] est_offset;
    logic signed [WORD_W-1:0] est_scale;
    logic [CNT_W-1:0] pairs_used;
    logic saturated;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0] cfg_data = '0;

    clock_drift_offset_estimator_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .time_ref        (time_ref),
        .time_remote     (time_remote),
        .update_estimate (update_estimate),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .est_offset      (est_offset),
        .est_scale       (est_scale),
        .pairs_used      (pairs_used),
        .saturated       (saturated),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // estimator state as the testbench sees it
    logic signed [WORD_W-1:0] init_offset_reg = '0;
    logic signed [WORD_W-1:0] init_scale_reg = SCALE_ONE;
    logic                     have_prev = 1'b0;
    logic signed [WORD_W-1:0] prev_ref = '0;
    logic signed [WORD_W-1:0] prev_remote = '0;
    logic signed [WORD_W-1:0] offset_sum = '0;
    logic signed [WORD_W-1:0] scale_sum = '0;
    logic [CNT_W-1:0]         interval_count = '0;
    logic signed [WORD_W-1:0] offset_now = '0;
    logic signed [WORD_W-1:0] scale_now = SCALE_ONE;
    logic                     step_clipped;

    estimate_t pending_estimates[$];

    int errors = 0;
    int pairs_sent = 0;
    int updates_sent = 0;
    int reg_writes = 0;
    int results_checked = 0;
    int clipped_results = 0;
    int idle_cycles = 0;
    int hold_off = 0;
    bit tight_input = 1'b0;
    bit out_stalls = 1'b1;

    function automatic logic signed [WORD_W-1:0] clip64(input wide_t v);
        if (v > WIDE_TOP)
        begin
            step_clipped = 1'b1;
            return MAX_POS;
        end
        if (v < WIDE_BOT)
        begin
            step_clipped = 1'b1;
            return MIN_MAG;
        end
        return v[WORD_W-1:0];
    endfunction

    function automatic logic signed [WORD_W-1:0] add_clipped(
        input logic signed [WORD_W-1:0] a,
        input logic signed [WORD_W-1:0] b
    );
        wide_t wa, wb;
        wa = a;
        wb = b;
        return clip64(wa + wb);
    endfunction

    function automatic logic signed [WORD_W-1:0] mean_of(input logic signed [WORD_W-1:0] total);
        wide_t num, den, q;
        num = total;
        den = interval_count;
        q = num / den;
        return q[WORD_W-1:0];
    endfunction

    function automatic void load_register(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [WORD_W-1:0] data);
        if (idx == CFG_INITIAL_OFFSET)
        begin
            init_offset_reg = data;
            if (interval_count == 0)
                offset_now = data;
        end
        else if (idx == CFG_INITIAL_SCALE)
        begin
            init_scale_reg = data;
            if (interval_count == 0)
                scale_now = data;
        end
    endfunction

    // Folds one timestamp pair into the sums and queues the resulting estimate.
    function automatic void fold_pair(input logic signed [WORD_W-1:0] a1,
                                      input logic signed [WORD_W-1:0] b1,
                                      input logic upd);
        wide_t a0w, b0w, a1w, b1w, da, db, sc, t;
        logic signed [WORD_W-1:0] interval_scale, interval_offset;
        estimate_t est;
        step_clipped = 1'b0;
        if (have_prev)
        begin
            a0w = prev_ref;
            b0w = prev_remote;
            a1w = a1;
            b1w = b1;
            da = a1w - a0w;
            db = b1w - b0w;
            if (da != 0)
            begin
                interval_scale = clip64((db <<< FRAC_BITS) / da);
                sc = interval_scale;
                // mean of both implied offsets, floored
                t = ((b0w + b1w) <<< FRAC_BITS) - sc * (a0w + a1w);
                interval_offset = clip64(t >>> (FRAC_BITS + 1));
                offset_sum = add_clipped(offset_sum, interval_offset);
                scale_sum = add_clipped(scale_sum, interval_scale);
                if (interval_count != CNT_MAX)
                    interval_count++;
            end
        end
        prev_ref = a1;
        prev_remote = b1;
        have_prev = 1'b1;
        if (upd && interval_count != 0)
        begin
            offset_now = mean_of(offset_sum);
            scale_now = mean_of(scale_sum);
        end
        est.offset = offset_now;
        est.scale = scale_now;
        est.pairs = interval_count;
        est.clipped = step_clipped;
        pending_estimates = {pending_estimates, est};
    endfunction

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [WORD_W-1:0] edge_or_random();
        case ($urandom_range(0, 5))
            0: return MIN_MAG;
            1: return MAX_POS;
            2: return '0;
            3: return '1;
            default: return rand_word();
        endcase
    endfunction

    // all driving tasks start and end on a falling edge
    task automatic send_pair(input logic signed [WORD_W-1:0] a,
                             input logic signed [WORD_W-1:0] b,
                             input logic upd);
        int gap;
        gap = (tight_input || $urandom_range(0, 1) == 0) ? 0 : idle_span();
        repeat (gap) @(negedge clk);
        time_ref = a;
        time_remote = b;
        update_estimate = upd;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        fold_pair(a, b, upd);
        pairs_sent++;
        if (upd)
            updates_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        load_register(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain_results();
        while (pending_estimates.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic end_phase();
        int pick;
        logic [CFG_IDX_W-1:0] stray;
        drain_results();
        pick = $urandom_range(0, 2);
        write_reg(CFG_INITIAL_OFFSET, pick == 0 ? MIN_MAG : pick == 1 ? MAX_POS : rand_word());
        pick = $urandom_range(0, 2);
        write_reg(CFG_INITIAL_SCALE, pick == 0 ? MAX_POS : pick == 1 ? MIN_MAG : rand_word());
        stray = CFG_IDX_W'($urandom_range(2, 255));
        write_reg(stray, rand_word());
    endtask

    // registers load straight into the estimate while no interval is counted
    task automatic test_register_preload();
        write_reg(CFG_INITIAL_OFFSET, MIN_MAG);
        write_reg(CFG_INITIAL_SCALE, MAX_POS);
        write_reg('1, rand_word());
        send_pair(64'sd0, 64'sd0, 1'b1);
        drain_results();
        write_reg(CFG_INITIAL_OFFSET, MAX_POS);
        write_reg(CFG_INITIAL_SCALE, MIN_MAG);
        send_pair(64'sd0, 64'sd12345, 1'b1);
        drain_results();
        write_reg(CFG_INITIAL_OFFSET, 64'hFFFF_FFFB_0000_0000);
        write_reg(CFG_INITIAL_SCALE, SCALE_ONE);
        write_reg(CFG_IDX_W'(2), rand_word());
        send_pair(64'sd0, 64'sd7, 1'b0);
    endtask

    task automatic test_first_intervals();
        send_pair(64'h0000_0001_0000_0000, 64'h0000_0001_0000_03E8, 1'b1);
        send_pair(64'h0000_0003_0000_0000, 64'h0000_0003_8000_0007, 1'b0);
        send_pair(64'h0000_0002_0000_0000, -64'sh4000_0000, 1'b1);
        send_pair(64'h0000_0005_0000_0001, -64'sh6_FFFF_FFFD, 1'b1);
    endtask

    task automatic test_extreme_timestamps();
        send_pair(MIN_MAG, MIN_MAG, 1'b0);
        send_pair(MAX_POS, MAX_POS, 1'b1);
        send_pair(MIN_MAG, MAX_POS, 1'b1);
        send_pair(MAX_POS, MIN_MAG, 1'b1);
        send_pair(-64'sd1, 64'sd0, 1'b1);
        send_pair(64'sd0, -64'sd1, 1'b1);
    endtask

    // remote clock follows offset + scale * reference with jitter, plus some noise
    task automatic test_drift_tracking();
        logic signed [WORD_W-1:0] ref_now, drift_offs, drift_scale, remote;
        logic [WORD_W-1:0] step;
        wide_t w, wo, wj;
        int jitter, run_left, r, n;
        run_left = 0;
        for (n = 0; n < 560; n++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(20, 60);
                ref_now = rand_word();
                ref_now = ref_now >>> $urandom_range(4, 24);
                drift_offs = rand_word();
                drift_offs = drift_offs >>> $urandom_range(8, 30);
                if ($urandom_range(0, 7) == 0)
                begin
                    drift_scale = rand_word();
                    drift_scale = drift_scale >>> 24;
                end
                else
                    drift_scale = SCALE_ONE + 64'($urandom_range(0, 32'h000F_FFFF)) - 64'h8_0000;
                tight_input = $urandom_range(0, 4) == 0;
                out_stalls = $urandom_range(0, 4) != 0;
            end
            run_left--;
            if (n == 280)
                drain_results();    // let the block run dry once mid-stream
            r = $urandom_range(0, 99);
            if (r >= 90)
                send_pair(edge_or_random(), edge_or_random(), $urandom_range(0, 3) == 0);
            else
            begin
                step = {30'b0, 2'($urandom_range(0, 3)), $urandom};
                if (r >= 6)
                    ref_now = ref_now + step;
                else if (r >= 3)
                    ref_now = ref_now - step;
                jitter = $urandom_range(0, 510) - 255;
                wj = jitter;
                w = drift_scale;
                wo = ref_now;
                w = (w * wo) >>> FRAC_BITS;
                wo = drift_offs;
                w = w + wo + wj;
                remote = w[WORD_W-1:0];
                send_pair(ref_now, remote, $urandom_range(0, 3) == 0);
            end
        end
        tight_input = 1'b0;
        out_stalls = 1'b1;
    endtask

    // huge slopes clip the scale, the offset and then the sums
    task automatic test_clipping();
        send_pair(64'sd10, 64'sd0, 1'b0);
        send_pair(64'sd11, MAX_POS, 1'b1);
        send_pair(64'sd12, MIN_MAG, 1'b1);
        send_pair(64'sd13, -64'sh100_0000_0000, 1'b1);
        send_pair(64'sd14, 64'sh100_0000_0000, 1'b1);
        send_pair(64'sd15, MAX_POS, 1'b1);
        send_pair(64'sd15, 64'sd0, 1'b1);
    endtask

    task automatic test_random_pairs();
        logic signed [WORD_W-1:0] a, b, last_a;
        int n, r;
        last_a = '0;
        for (n = 0; n < 270; n++)
        begin
            if (n % 50 == 0)
            begin
                tight_input = $urandom_range(0, 3) == 0;
                out_stalls = $urandom_range(0, 3) != 0;
            end
            r = $urandom_range(0, 99);
            if (r < 5)
                a = last_a;
            else if (r < 40)
                a = $signed(rand_word()) >>> $urandom_range(16, 40);
            else
                a = edge_or_random();
            b = ($urandom_range(0, 2) == 0) ? $signed(rand_word()) >>> $urandom_range(16, 40)
                                            : $signed(edge_or_random());
            send_pair(a, b, $urandom_range(0, 9) < 3);
            last_a = a;
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            out_ready = 1'b0;
            hold_off--;
        end
        else
        begin
            out_ready = 1'b1;
            if (out_stalls && $urandom_range(0, 3) == 0)
                hold_off = idle_span();
        end
    end

    always @(posedge clk)
    begin : check_results
        estimate_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_estimates.size() == 0)
            begin
                errors++;
                $error("result item with no pair outstanding");
            end
            else
            begin
                want = pending_estimates.pop_front();
                results_checked++;
                if (want.clipped)
                    clipped_results++;
                if (est_offset !== want.offset)
                begin
                    errors++;
                    $error("est_offset: expected %0d, got %0d", want.offset, est_offset);
                end
                if (est_scale !== want.scale)
                begin
                    errors++;
                    $error("est_scale: expected %0d, got %0d", want.scale, est_scale);
                end
                if (pairs_used !== want.pairs)
                begin
                    errors++;
                    $error("pairs_used: expected %0d, got %0d", want.pairs, pairs_used);
                end
                if (saturated !== want.clipped)
                begin
                    errors++;
                    $error("saturated: expected %0b, got %0b", want.clipped, saturated);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_estimates.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        test_register_preload();
        test_first_intervals();
        end_phase();
        test_extreme_timestamps();
        end_phase();
        test_drift_tracking();
        end_phase();
        test_clipping();
        end_phase();
        test_random_pairs();
        drain_results();
        $display("%0d timestamp pairs (%0d with estimate update), %0d register writes",
                 pairs_sent, updates_sent, reg_writes);
        $display("%0d results checked, %0d of them clipped, final interval count %0d",
                 results_checked, clipped_results, interval_count);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
